// File: rtl/binary_min_heap_top_defines.svh
// Assertion macros for the heap RTL
`ifndef BINARY_MIN_HEAP_TOP_DEFINES_SVH
`define BINARY_MIN_HEAP_TOP_DEFINES_SVH

// a implies b in the next cycle
`define BMH_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("%m: check failed");

// a implies b in the same cycle
`define BMH_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("%m: check failed");

`endif

// File: rtl/bmh_pkg.sv
//------------------------------------------------------------------------------
// bmh_pkg
// Shared constants and types for the binary heap priority queue.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bmh_pkg;
    localparam int Capacity = 1024;
    localparam int KeyW     = 32;
    localparam int AddrW    = $clog2(Capacity);
    localparam int CountW   = AddrW + 1;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    localparam logic [0:0] REG_ORDER = 1'b0;

    typedef logic [KeyW-1:0]   t_key;
    typedef logic [AddrW-1:0]  t_addr;
    typedef logic [CountW-1:0] t_count;
endpackage
`default_nettype wire

// File: rtl/binary_min_heap_top.sv
// Operations run one at a time: o_stall is high from acceptance until the result is
// registered on o_valid, and a new transaction can be taken while o_valid is high.
// Errors and the unused code go straight to the result; each step does at most one
// memory read. Sync active-low reset clears count, order and control; memory
// undefined until written.
//------------------------------------------------------------------------------
// binary_min_heap_top
// Array heap in one memory with insert, remove-at and find, walked by a
// small sequencer around its key comparisons.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "binary_min_heap_top_defines.svh"
module binary_min_heap_top
    import bmh_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_key,
    input  wire logic [9:0]  i_position,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [9:0]       o_where,
    output logic [31:0]      o_removed_key,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam logic [3:0] S_IDLE = 4'd0, S_UP_RD = 4'd1, S_UP_CMP = 4'd2,
        S_RM_RD = 4'd3, S_RM_LAST = 4'd4, S_RM_PAR = 4'd5, S_DN_L = 4'd6,
        S_DN_R = 4'd7, S_DN_CMP = 4'd8, S_F_RD = 4'd9, S_F_CMP = 4'd10,
        S_DONE = 4'd11, S_RM_PCMP = 4'd12, S_WAIT = 4'd13, S_F_UP = 4'd14;

    t_key   r_mem [Capacity];
    t_key   r_rdata;
    logic   r_order;
    logic [3:0] r_state;
    t_count r_count;
    logic [1:0] r_op;
    t_key   r_cur;     // key moving through the tree, or search key
    t_key   r_lkey;    // left child key
    logic   r_rvalid;  // right child exists
    t_addr  r_idx, r_start;
    logic [1:0] r_status;
    t_addr  r_where;
    t_key   r_removed;
    logic   r_ovalid;
    logic [1:0] r_ostatus;
    t_addr  r_owhere;
    t_key   r_oremoved;

    logic   we;
    t_addr  waddr;
    t_key   wdata;
    logic   rd;
    t_addr  raddr;
    t_addr  parent;
    t_count lch, rch;
    logic   take_r;
    t_key   best_key;
    t_addr  best_idx;
    logic   acc;
    logic   out_free;

    function automatic logic key_first(input t_key a, input t_key b, input logic d);
        key_first = d ? (a > b) : (a < b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (rd) r_rdata <= r_mem[raddr];
    end

    assign pready = 1'b1;
    assign prdata = {31'd0, r_order};
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_where = r_owhere;
    assign o_removed_key = r_oremoved;

    assign parent = t_addr'((r_idx - 1'b1) >> 1);
    assign lch = {r_idx, 1'b1};
    assign rch = {r_idx, 1'b0} + t_count'(2);
    // right child wins a tie
    assign take_r = r_rvalid && !key_first(r_lkey, r_rdata, r_order);
    assign best_key = take_r ? r_rdata : r_lkey;
    assign best_idx = take_r ? t_addr'(rch) : t_addr'(lch);
    assign acc = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    // memory access decode (combinational on state)
    always_comb begin
        we = 1'b0; waddr = r_idx; wdata = r_cur; rd = 1'b0; raddr = r_idx;
        case (r_state)
            S_UP_RD, S_RM_PAR: begin rd = 1'b1; raddr = parent; end
            S_RM_RD, S_F_RD: rd = 1'b1;
            S_RM_LAST: begin rd = 1'b1; raddr = t_addr'(r_count); end
            S_DN_L: begin rd = 1'b1; raddr = t_addr'(lch); end
            S_DN_R: begin rd = 1'b1; raddr = t_addr'(rch); end
            S_UP_CMP, S_RM_PCMP: if (key_first(r_cur, r_rdata, r_order)) begin
                we = 1'b1; wdata = r_rdata;
            end
            S_DN_CMP: if (key_first(best_key, r_cur, r_order)) begin
                we = 1'b1; wdata = best_key;
            end
            S_WAIT: we = 1'b1; // write moving key home
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_order <= 1'b0; r_ovalid <= 1'b0;
            r_ostatus <= '0; r_owhere <= '0; r_oremoved <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == REG_ORDER)
                r_order <= pwdata[0];
            if (r_state == S_DONE && out_free) r_ovalid <= 1'b1;
            else if (!i_stall) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (acc) begin
                    r_op <= i_operation; r_cur <= i_key; r_start <= i_position;
                    r_idx <= (i_operation == OP_INSERT) ? t_addr'(r_count) : i_position;
                    r_where <= '0; r_removed <= '0;
                    case (i_operation)
                        OP_INSERT:
                            if (r_count >= t_count'(Capacity-1)) begin
                                r_status <= ST_FULL; r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_count <= r_count + 1'b1;
                                r_state <= (r_count == '0) ? S_WAIT : S_UP_RD;
                            end
                        OP_REMOVE:
                            if (t_count'(i_position) >= r_count) begin
                                r_status <= ST_RANGE; r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_count <= r_count - 1'b1;
                                r_state <= S_RM_RD;
                            end
                        OP_FIND:
                            if (t_count'(i_position) >= r_count) begin
                                r_status <= ST_NOTFOUND; r_state <= S_DONE;
                            end else begin
                                r_status <= ST_OK; r_state <= S_F_RD;
                            end
                        default: begin
                            r_status <= ST_OK; r_state <= S_DONE;
                        end
                    endcase
                end
                S_UP_RD: r_state <= S_UP_CMP;
                S_UP_CMP, S_RM_PCMP:
                    if (key_first(r_cur, r_rdata, r_order)) begin
                        r_idx <= parent;
                        r_state <= (parent == '0) ? S_WAIT : S_UP_RD;
                    end else begin
                        // a moved key that does not climb sinks instead
                        r_state <= (r_state == S_RM_PCMP) ? S_DN_L : S_WAIT;
                    end
                S_WAIT: begin
                    if (r_op == OP_INSERT) r_where <= r_idx;
                    r_state <= S_DONE;
                end
                S_RM_RD: r_state <= S_RM_LAST;
                S_RM_LAST: begin
                    r_removed <= r_rdata;
                    r_state <= (t_count'(r_idx) == r_count) ? S_DONE : S_RM_PAR;
                end
                S_RM_PAR: begin
                    r_cur <= r_rdata;
                    r_state <= (r_idx == '0) ? S_DN_L : S_RM_PCMP;
                end
                S_DN_L: r_state <= (lch >= r_count) ? S_WAIT : S_DN_R;
                S_DN_R: begin
                    r_lkey <= r_rdata;
                    r_rvalid <= (rch < r_count);
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP:
                    if (key_first(best_key, r_cur, r_order)) begin
                        r_idx <= best_idx; r_state <= S_DN_L;
                    end else r_state <= S_WAIT;
                S_F_RD: r_state <= S_F_CMP;
                S_F_CMP:
                    if (r_rdata == r_cur) begin
                        r_where <= r_idx; r_state <= S_DONE;
                    end else if (key_first(r_rdata, r_cur, r_order) && rch < r_count) begin
                        r_idx <= t_addr'(rch); r_state <= S_F_RD;
                    end else if (key_first(r_rdata, r_cur, r_order) && lch < r_count) begin
                        r_idx <= t_addr'(lch); r_state <= S_F_RD;
                    end else r_state <= S_F_UP;
                // climb to the next pending left sibling, stop at the start node
                S_F_UP:
                    if (r_idx == r_start) begin
                        r_status <= ST_NOTFOUND; r_state <= S_DONE;
                    end else if (!r_idx[0]) begin
                        r_idx <= r_idx - 1'b1; r_state <= S_F_RD;
                    end else r_idx <= parent;
                S_DONE: if (out_free) begin
                    r_ostatus <= r_status; r_owhere <= r_where; r_oremoved <= r_removed;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BMH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `BMH_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, o_valid && i_stall, $stable({o_status, o_where, o_removed_key}))
    `BMH_ASSERT_NOW(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_count < t_count'(Capacity))
endmodule
`default_nettype wire

// File: test/binary_min_heap_top_tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// binary_min_heap_top_tb
// Self-checking bench for the heap priority queue: a directed table, then
// random phases under both key orders, a fill to the full limit and a
// partial drain, with sender gaps and receiver stalls. Every result is
// compared with a behavioral heap kept inside the bench, or with the table's result for typed rows.
//------------------------------------------------------------------------------
module binary_min_heap_top_tb;
    import bmh_pkg::*;

    localparam int LIMIT_CYCLES = 20000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  where_idx;
        logic [31:0] removed;
    } t_result;

    typedef struct {
        logic [1:0]  op;
        logic [31:0] key;
        logic [9:0]  pos;
        bit          typed;
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_operation;
    logic [31:0] i_key;
    logic [9:0]  i_position;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [9:0]  o_where;
    logic [31:0] o_removed_key;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    binary_min_heap_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation), .i_key(i_key), .i_position(i_position),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_where(o_where), .o_removed_key(o_removed_key),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // bench copy of the heap
    logic [31:0] heap_mem [Capacity] = '{default: '0};
    int unsigned heap_cnt = 0;
    bit          order_desc;

    t_result     pending_q [$];
    bit          row_typed;
    t_result     row_res;
    int          idle_mode;
    int          err_cnt = 0;
    longint      cycle_cnt = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit precedes(logic [31:0] a, logic [31:0] b);
        return order_desc ? (a > b) : (a < b);
    endfunction

    function automatic void swap_keys(int unsigned a, int unsigned b);
        logic [31:0] t;
        t = heap_mem[a];
        heap_mem[a] = heap_mem[b];
        heap_mem[b] = t;
    endfunction

    function automatic int unsigned climb(int unsigned idx);
        while (idx > 0 && precedes(heap_mem[idx], heap_mem[(idx - 1) / 2])) begin
            swap_keys(idx, (idx - 1) / 2);
            idx = (idx - 1) / 2;
        end
        return idx;
    endfunction

    function automatic void sink(int unsigned idx);
        int unsigned l, r, best;
        forever begin
            l = 2 * idx + 1;
            r = 2 * idx + 2;
            if (r < heap_cnt) best = precedes(heap_mem[l], heap_mem[r]) ? l : r;
            else if (l < heap_cnt) best = l;
            else return;
            if (!precedes(heap_mem[best], heap_mem[idx])) return;
            swap_keys(idx, best);
            idx = best;
        end
    endfunction

    // pruned preorder search, right subtree first
    function automatic bit search_from(int unsigned start, logic [31:0] key,
                                       output int unsigned hit);
        int unsigned node;
        bit down;
        node = start;
        hit = 0;
        forever begin
            if (heap_mem[node] == key) begin
                hit = node;
                return 1'b1;
            end
            down = 1'b0;
            if (precedes(heap_mem[node], key)) begin
                if (2 * node + 2 < heap_cnt) begin
                    node = 2 * node + 2;
                    down = 1'b1;
                end else if (2 * node + 1 < heap_cnt) begin
                    node = 2 * node + 1;
                    down = 1'b1;
                end
            end
            if (!down) begin
                forever begin
                    if (node == start) return 1'b0;
                    if (node[0] == 1'b0) begin
                        node = node - 1;
                        break;
                    end
                    node = (node - 1) / 2;
                end
            end
        end
    endfunction

    function automatic t_result heap_step(logic [1:0] op, logic [31:0] key,
                                          logic [9:0] pos);
        t_result r;
        int unsigned hit;
        r = '0;
        case (op)
            OP_INSERT: begin
                if (heap_cnt >= Capacity - 1) begin
                    r.status = ST_FULL;
                end else begin
                    heap_mem[heap_cnt] = key;
                    heap_cnt++;
                    r.where_idx = 10'(climb(heap_cnt - 1));
                end
            end
            OP_REMOVE: begin
                if (pos >= heap_cnt) begin
                    r.status = ST_RANGE;
                end else begin
                    r.removed = heap_mem[pos];
                    heap_cnt--;
                    if (pos != heap_cnt) begin
                        heap_mem[pos] = heap_mem[heap_cnt];
                        if (pos > 0 && precedes(heap_mem[pos], heap_mem[(pos - 1) / 2]))
                            void'(climb(pos));
                        else
                            sink(pos);
                    end
                end
            end
            OP_FIND: begin
                if (pos < heap_cnt && search_from(pos, key, hit)) r.where_idx = 10'(hit);
                else r.status = ST_NOTFOUND;
            end
            default: ;
        endcase
        return r;
    endfunction

    // transaction monitor and scoreboard
    always @(posedge i_clk) begin
        t_result got, want;
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            want = heap_step(i_operation, i_key, i_position);
            if (row_typed) want = row_res;
            pending_q.push_back(want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_where, o_removed_key};
            if (pending_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) $display("unexpected result %h", got);
            end else begin
                want = pending_q.pop_front();
                if (got !== want) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("mismatch: exp st=%0d wh=%0d rk=%h, got st=%0d wh=%0d rk=%h",
                                 want.status, want.where_idx, want.removed,
                                 got.status, got.where_idx, got.removed);
                end
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        case (idle_mode)
            2:       i_stall <= ($urandom_range(99) < 79);
            3:       i_stall <= ($urandom_range(99) < 8);
            default: i_stall <= 1'b0;
        endcase
    end

    task automatic send(logic [1:0] op, logic [31:0] key, logic [9:0] pos,
                        bit typed, t_result res);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 79 : (idle_mode == 3) ? 8 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        i_position  <= pos;
        row_typed   <= typed;
        row_res     <= res;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_order(bit desc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ORDER, 2'b00};
        pwdata  <= {31'd0, desc};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        order_desc = desc;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'h0;
            2, 3, 4: return $urandom;
            default: return $urandom_range(31);
        endcase
    endfunction

    task automatic random_items(int n);
        int unsigned sel, cnt;
        logic [1:0]  op;
        logic [31:0] key;
        logic [9:0]  pos;
        for (int k = 0; k < n; k++) begin
            cnt = heap_cnt;
            sel = $urandom_range(99);
            key = pick_key();
            pos = 10'($urandom);
            if (sel < 45 || cnt < 3) begin
                op = OP_INSERT;
            end else if (sel < 75) begin
                op = OP_REMOVE;
                if ($urandom_range(9) != 0) pos = 10'($urandom_range(cnt - 1));
            end else if (sel < 95) begin
                op = OP_FIND;
                if ($urandom_range(3) != 0)
                    pos = $urandom_range(1) ? 10'd0 : 10'($urandom_range(cnt - 1));
                if ($urandom_range(1)) key = heap_mem[$urandom_range(cnt - 1)];
            end else begin
                op = 2'd3;
            end
            send(op, key, pos, 1'b0, '0);
        end
    endtask

    t_row dir_rows [] = '{
        '{OP_REMOVE, 32'h0,         10'd0,     1'b1, '{ST_RANGE, 10'd0, 32'h0}},
        '{OP_FIND,   32'h0,         10'd0,     1'b1, '{ST_NOTFOUND, 10'd0, 32'h0}},
        '{2'd3,      32'h1234_5678, 10'd5,     1'b1, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'hFFFF_FFFF, 10'h3FF,   1'b1, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'h0,         10'd0,     1'b1, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'd7,         10'h2AA,   1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'd7,         10'h155,   1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'd3,         10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_FIND,   32'hFFFF_FFFF, 10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_FIND,   32'd7,         10'h3FF,   1'b1, '{ST_NOTFOUND, 10'd0, 32'h0}},
        '{OP_REMOVE, 32'h0,         10'h3FF,   1'b1, '{ST_RANGE, 10'd0, 32'h0}},
        '{OP_FIND,   32'd8,         10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_FIND,   32'd7,         10'd1,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_REMOVE, 32'hAAAA_AAAA, 10'd0,     1'b1, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'hAAAA_AAAA, 10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'h5555_5555, 10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_INSERT, 32'd7,         10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_REMOVE, 32'h0,         10'd2,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{2'd3,      32'hFFFF_FFFF, 10'h3FF,   1'b1, '{ST_OK, 10'd0, 32'h0}},
        '{OP_REMOVE, 32'h5555_5555, 10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}},
        '{OP_FIND,   32'hAAAA_AAAA, 10'd0,     1'b0, '{ST_OK, 10'd0, 32'h0}}
    };

    initial begin
        int unsigned n;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = OP_INSERT;
        i_key       = '0;
        i_position  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        row_typed   = 1'b0;
        row_res     = '0;
        idle_mode   = 0;
        order_desc  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_order(1'b0);

        foreach (dir_rows[j])
            send(dir_rows[j].op, dir_rows[j].key, dir_rows[j].pos,
                 dir_rows[j].typed, dir_rows[j].res);
        drain();    // sender holds off until every result is back

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            write_order(ph[0]);
            random_items(30);
            drain();
        end

        // fill to the limit, overflow, then take some keys out (max order)
        idle_mode = 0;
        write_order(1'b1);
        n = Capacity - 1 - heap_cnt + 3;
        for (int k = 0; k < n; k++) send(OP_INSERT, pick_key(), 10'($urandom), 1'b0, '0);
        drain();
        n = heap_cnt;
        idle_mode = 3;
        for (int k = 0; k < 40; k++)
            send(OP_REMOVE, $urandom, 10'($urandom_range(n - 1 - k)), 1'b0, '0);
        drain();

        if (err_cnt == 0 && pending_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
